>>> rtl/core/property_lookup_cache_core_macros.svh
// Assertion macros shared by the property lookup cache core.
// Depends on a clock named clock and an active-high reset named reset in the including scope.
`ifndef PROPERTY_LOOKUP_CACHE_CORE_MACROS_SVH
`define PROPERTY_LOOKUP_CACHE_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/plc_pkg.sv
// Shared types and constants of the property lookup cache core.
// No dependencies; imported by the controller, the datapath and the top level.
package plc_pkg;

   localparam int DEF_ROW_BITS = 8;
   localparam int DEF_WAYS     = 2;
   localparam int DEF_ID_BITS  = 16;

   localparam int HASH_W  = 8;
   localparam int FIELD_W = 16;

   typedef enum logic [1:0] {
      OP_LOOKUP     = 2'd0,
      OP_INSERT     = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef struct packed {
      logic capture;   // latch request and read its row
      logic commit;    // write back the row and load the response
      logic clear_wr;  // clear the valid bits of one row of the sweep
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_clear;    // latched operation is clear all
      logic clear_last;  // sweep is at its last row
      logic rsp_busy;    // response register holds an untaken result
   } ctrl_sts_type;

endpackage

>>> rtl/core/plc_ctrl.sv
// Controller state machine of the property lookup cache core.
// Depends on plc_pkg for the command and status types.
module plc_ctrl import plc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      cmd.clear_wr = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The row is written back only once the result has a place to go.
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = sts.op_clear ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/plc_datapath.sv
// Datapath of the property lookup cache core: row memories, way compare and update, response.
// Depends on plc_pkg; driven by plc_ctrl through the command struct.
module plc_datapath import plc_pkg::*; #(
   parameter int ROW_BITS = DEF_ROW_BITS,
   parameter int WAYS     = DEF_WAYS,
   parameter int ID_BITS  = DEF_ID_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output ctrl_sts_type       sts,
   input  logic [1:0]         req_operation,
   input  logic [HASH_W-1:0]  req_row_hash,
   input  logic [FIELD_W-1:0] req_object_id,
   input  logic [FIELD_W-1:0] req_name_id,
   input  logic [FIELD_W-1:0] req_property_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [FIELD_W-1:0] rsp_property_out
);

   localparam int NUM_ROWS = 1 << ROW_BITS;

   // Row memories, one word per row holding all ways.
   logic [WAYS-1:0]               mem_valid [NUM_ROWS];
   logic [WAYS-1:0][ID_BITS-1:0]  mem_obj   [NUM_ROWS];
   logic [WAYS-1:0][ID_BITS-1:0]  mem_nam   [NUM_ROWS];
   logic [WAYS-1:0][ID_BITS-1:0]  mem_prp   [NUM_ROWS];

   logic [WAYS-1:0]               rd_valid_ff;
   logic [WAYS-1:0][ID_BITS-1:0]  rd_obj_ff, rd_nam_ff, rd_prp_ff;

   op_type                        op_ff;
   logic [ROW_BITS-1:0]           row_ff, row_in;
   logic [ID_BITS-1:0]            obj_ff, nam_ff, prp_ff;

   logic [ROW_BITS-1:0]           clr_cnt_ff, clr_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [FIELD_W-1:0]            rsp_prop_ff, rsp_prop_in;

   logic [WAYS-1:0]               match, match_oh, keep, free, free_oh, slot_oh;
   logic [WAYS-1:0]               inv_valid, ins_valid, new_valid, wr_valid;
   logic [WAYS-1:0][ID_BITS-1:0]  new_obj, new_nam, new_prp;
   logic [ID_BITS-1:0]            pout;
   logic                          full, valid_we, fields_we;
   logic [ROW_BITS-1:0]           wr_addr;

   assign row_in = ROW_BITS'(req_row_hash);

   // Request capture and registered row read.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= op_type'(req_operation);
         row_ff      <= row_in;
         obj_ff      <= ID_BITS'(req_object_id);
         nam_ff      <= ID_BITS'(req_name_id);
         prp_ff      <= ID_BITS'(req_property_id);
         rd_valid_ff <= mem_valid[row_in];
         rd_obj_ff   <= mem_obj[row_in];
         rd_nam_ff   <= mem_nam[row_in];
         rd_prp_ff   <= mem_prp[row_in];
      end
      if (valid_we) begin
         mem_valid[wr_addr] <= wr_valid;
      end
      if (fields_we) begin
         mem_obj[row_ff] <= new_obj;
         mem_nam[row_ff] <= new_nam;
         mem_prp[row_ff] <= new_prp;
      end
   end

   // Per-way compares; all ways are examined in parallel.
   always_comb begin
      pout = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w]     = rd_valid_ff[w] && (rd_obj_ff[w] == obj_ff) && (rd_nam_ff[w] == nam_ff);
         keep[w]      = rd_valid_ff[w] && !((prp_ff != '0) && (rd_prp_ff[w] == prp_ff));
         inv_valid[w] = rd_valid_ff[w] && !((rd_obj_ff[w] == obj_ff) && (rd_prp_ff[w] == prp_ff));
      end
      // Lowest matching way wins.
      match_oh = match & (~match + WAYS'(1));
      for (int w = 0; w < WAYS; w++) begin
         if (match_oh[w]) begin
            pout = pout | rd_prp_ff[w];
         end
      end
      free      = ~keep;
      free_oh   = free & (~free + WAYS'(1));
      full      = (free == '0);
      // A full row is emptied and refilled from way 0.
      slot_oh   = full ? WAYS'(1) : free_oh;
      ins_valid = (full ? '0 : keep) | slot_oh;
      for (int w = 0; w < WAYS; w++) begin
         new_obj[w] = slot_oh[w] ? obj_ff : rd_obj_ff[w];
         new_nam[w] = slot_oh[w] ? nam_ff : rd_nam_ff[w];
         new_prp[w] = slot_oh[w] ? prp_ff : rd_prp_ff[w];
      end
   end

   always_comb begin
      new_valid   = rd_valid_ff;
      rsp_hit_in  = 1'b0;
      rsp_prop_in = '0;
      unique case (op_ff)
         OP_LOOKUP: begin
            rsp_hit_in  = |match;
            rsp_prop_in = FIELD_W'(pout);
         end
         OP_INSERT:     new_valid = ins_valid;
         OP_INVALIDATE: new_valid = inv_valid;
         OP_CLEAR:      new_valid = rd_valid_ff;
         default:       new_valid = rd_valid_ff;
      endcase
   end

   assign valid_we  = cmd.clear_wr
                      || (cmd.commit && ((op_ff == OP_INSERT) || (op_ff == OP_INVALIDATE)));
   assign fields_we = cmd.commit && (op_ff == OP_INSERT);
   assign wr_addr   = cmd.clear_wr ? clr_cnt_ff : row_ff;
   assign wr_valid  = cmd.clear_wr ? '0 : new_valid;

   // The sweep counter wraps to zero after its last row.
   assign clr_cnt_in   = cmd.clear_wr ? clr_cnt_ff + ROW_BITS'(1) : clr_cnt_ff;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_prop_ff <= rsp_prop_in;
      end
   end

   assign sts.op_clear   = (op_ff == OP_CLEAR);
   assign sts.clear_last = &clr_cnt_ff;
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_property_out = rsp_prop_ff;

endmodule

>>> rtl/core/property_lookup_cache_core.sv
// Property lookup cache core: set-associative cache keyed by object and name id.
// An item is accepted with its row read, then its row is written back and its result registered,
// so no new item is taken before that write-back, which waits while a result is still untaken.
// Clear all adds a sweep of 2^ROW_BITS rows (256 by default), one row per cycle.
// After synchronous reset the same sweep runs over all 2^ROW_BITS rows with req_stall high.
module property_lookup_cache_core import plc_pkg::*; #(
   parameter int ROW_BITS = DEF_ROW_BITS,
   parameter int WAYS     = DEF_WAYS,
   parameter int ID_BITS  = DEF_ID_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [HASH_W-1:0]  req_row_hash,
   input  logic [FIELD_W-1:0] req_object_id,
   input  logic [FIELD_W-1:0] req_name_id,
   input  logic [FIELD_W-1:0] req_property_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [FIELD_W-1:0] rsp_property_out
);

`include "property_lookup_cache_core_macros.svh"

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   plc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   plc_datapath #(
      .ROW_BITS (ROW_BITS),
      .WAYS     (WAYS),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_row_hash     (req_row_hash),
      .req_object_id    (req_object_id),
      .req_name_id      (req_name_id),
      .req_property_id  (req_property_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_property_out (rsp_property_out)
   );

   // A transfer in is always followed by a busy cycle while its row is processed.
   `PLC_ASSERT_NEXT(a_accept_then_busy, req_valid && !req_stall, req_stall, "accept not followed by busy")
   // No request may be taken while the clearing sweep writes the memory.
   `PLC_ASSERT_SAME(a_sweep_blocks_req, cmd.clear_wr, req_stall, "request open during sweep")
   // A write-back always produces a visible result in the next cycle.
   `PLC_ASSERT_NEXT(a_commit_gives_rsp, cmd.commit, rsp_valid, "commit without response")
   // A write-back never overwrites a result that is still waiting.
   `PLC_ASSERT_SAME(a_commit_rsp_free, cmd.commit, !(rsp_valid && rsp_stall), "response overwritten")

endmodule
